/* rtl/bqec_pkg.sv */
// Shared types, codes and helpers for the buffer queue with event coalescing.
// No dependencies; the modules refer to it by scoped names, the two interfaces do not use it.
package bqec_pkg;

   typedef enum logic [2:0] {
      OP_SEND     = 3'd0,
      OP_RECV     = 3'd1,
      OP_SIG_FULL = 3'd2,
      OP_CONFIRM  = 3'd3,
      OP_DISCON   = 3'd4,
      OP_ACTIVATE = 3'd5,
      OP_CONNECT  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_DATA_READY  = 3'd1,
      EV_SPACE_READY = 3'd2,
      EV_DISCONNECT  = 3'd3,
      EV_PORT_ERROR  = 3'd4,
      EV_START       = 3'd5,
      EV_STOP        = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_CONFIRM = 2'd1,
      MODE_PER_OP  = 2'd2,
      MODE_EVERY   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_CONS_MODE   = 3'd0,
      REG_PROD_MODE   = 3'd1,
      REG_BLOCK_CONN  = 3'd2,
      REG_BLOCK_UNCON = 3'd3,
      REG_CONS_ID     = 3'd4,
      REG_PROD_ID     = 3'd5
   } reg_idx_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } fsm_state_type;

   localparam logic [1:0] ARM_HELD_CONFIRM = 2'd1;
   localparam logic [1:0] ARM_HELD_OP      = 2'd2;
   localparam logic [1:0] ARM_READY        = 2'd3;

   localparam logic SIDE_CONS = 1'b0;
   localparam logic SIDE_PROD = 1'b1;

   localparam int ADDR_BITS = 5;

   typedef struct packed {
      logic [1:0] cons_mode;
      logic [1:0] prod_mode;
      logic       block_conn;
      logic       block_uncon;
      logic [7:0] cons_id;
      logic [7:0] prod_id;
   } cfg_type;

   typedef struct packed {
      logic cons;
      logic prod;
   } id_clear_type;

   typedef struct packed {
      logic latch;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

   typedef struct packed {
      logic       fire;
      logic [1:0] arm;
   } arm_result_type;

   // Decide whether a side is notified and where its arm goes afterwards.
   function automatic arm_result_type arm_fire(logic [1:0] mode, logic [1:0] arm);
      arm_result_type r;
      r.fire = 1'b0;
      r.arm  = arm;
      case (mode_type'(mode))
         MODE_CONFIRM: begin
            if (arm == ARM_READY) begin
               r.fire = 1'b1;
               r.arm  = ARM_HELD_CONFIRM;
            end
         end
         MODE_PER_OP: begin
            if (arm == ARM_READY) begin
               r.fire = 1'b1;
               r.arm  = ARM_HELD_OP;
            end
         end
         MODE_EVERY: r.fire = 1'b1;
         default:    r.fire = 1'b0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/bqec_req_if.sv */
// Request channel: valid/ready handshake carrying one queue operation.
// Depends on nothing; width of the pushed word is a parameter.
interface bqec_req_if #(
   parameter int WORD_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic [2:0]           opcode;
   logic                 side;
   logic                 flag;
   logic [WORD_BITS-1:0] write_word;

   modport source (output valid, opcode, side, flag, write_word, input ready);
   modport sink   (input valid, opcode, side, flag, write_word, output ready);
endinterface

/* rtl/bqec_rsp_if.sv */
// Response channel: valid/ready handshake carrying one operation result.
// Depends on nothing; word and fill widths are parameters.
interface bqec_rsp_if #(
   parameter int WORD_BITS = 32,
   parameter int FILL_BITS = 5
);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] read_word;
   logic                 read_valid;
   logic                 dropped_oldest;
   logic                 push_failed;
   logic [2:0]           event_code;
   logic                 event_side;
   logic [7:0]           event_port_id;
   logic [FILL_BITS-1:0] fill_level;

   modport source (output valid, read_word, read_valid, dropped_oldest, push_failed,
                   event_code, event_side, event_port_id, fill_level, input ready);
   modport sink   (input valid, read_word, read_valid, dropped_oldest, push_failed,
                   event_code, event_side, event_port_id, fill_level, output ready);
endinterface

/* rtl/bqec_csr.sv */
// APB-style register file for modes, blocking policy and port ids.
// Depends on bqec_pkg; the datapath may clear a port id on disconnect.
module bqec_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bqec_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   input  bqec_pkg::id_clear_type        id_clear,
   output bqec_pkg::cfg_type             cfg
);
   bqec_pkg::cfg_type   cfg_ff;
   bqec_pkg::cfg_type   cfg_in;
   bqec_pkg::reg_idx_type idx;
   logic                wr_en;

   assign idx    = bqec_pkg::reg_idx_type'(paddr[bqec_pkg::ADDR_BITS-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (id_clear.cons) begin
         cfg_in.cons_id = '0;
      end
      if (id_clear.prod) begin
         cfg_in.prod_id = '0;
      end
      if (wr_en) begin
         case (idx)
            bqec_pkg::REG_CONS_MODE:   cfg_in.cons_mode   = pwdata[1:0];
            bqec_pkg::REG_PROD_MODE:   cfg_in.prod_mode   = pwdata[1:0];
            bqec_pkg::REG_BLOCK_CONN:  cfg_in.block_conn  = pwdata[0];
            bqec_pkg::REG_BLOCK_UNCON: cfg_in.block_uncon = pwdata[0];
            bqec_pkg::REG_CONS_ID:     cfg_in.cons_id     = pwdata[7:0];
            bqec_pkg::REG_PROD_ID:     cfg_in.prod_id     = pwdata[7:0];
            default:                   cfg_in = cfg_in;
         endcase
      end
   end

   always_comb begin
      case (idx)
         bqec_pkg::REG_CONS_MODE:   prdata = {30'd0, cfg_ff.cons_mode};
         bqec_pkg::REG_PROD_MODE:   prdata = {30'd0, cfg_ff.prod_mode};
         bqec_pkg::REG_BLOCK_CONN:  prdata = {31'd0, cfg_ff.block_conn};
         bqec_pkg::REG_BLOCK_UNCON: prdata = {31'd0, cfg_ff.block_uncon};
         bqec_pkg::REG_CONS_ID:     prdata = {24'd0, cfg_ff.cons_id};
         bqec_pkg::REG_PROD_ID:     prdata = {24'd0, cfg_ff.prod_id};
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cons_mode   <= 2'd0;
         cfg_ff.prod_mode   <= 2'd0;
         cfg_ff.block_conn  <= 1'b1;
         cfg_ff.block_uncon <= 1'b0;
         cfg_ff.cons_id     <= 8'd0;
         cfg_ff.prod_id     <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

/* rtl/bqec_ctrl.sv */
// Controller: two-state sequencer that accepts an operation and commits it.
// Depends on bqec_pkg for the state enum and the command/status structs.
module bqec_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bqec_pkg::dp_status_type  status,
   output bqec_pkg::ctrl_cmd_type   cmd
);
   bqec_pkg::fsm_state_type state_ff;
   bqec_pkg::fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqec_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.latch  = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         bqec_pkg::ST_IDLE: begin
            // take nothing while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.latch = 1'b1;
               state_in  = bqec_pkg::ST_EXEC;
            end
         end
         bqec_pkg::ST_EXEC: begin
            // hold until the previous result beat has left the output register
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = bqec_pkg::ST_IDLE;
            end
         end
         default: state_in = bqec_pkg::ST_IDLE;
      endcase
   end
endmodule

/* rtl/bqec_dp.sv */
// Datapath: queue memory, head/count, arm and connection state, result register.
// Depends on bqec_pkg; driven by commands from bqec_ctrl.
module bqec_dp #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32,
   parameter int FILL_BITS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bqec_pkg::ctrl_cmd_type cmd,
   output bqec_pkg::dp_status_type status,
   input  bqec_pkg::cfg_type      cfg,
   output bqec_pkg::id_clear_type id_clear,
   input  logic [2:0]             req_opcode,
   input  logic                   req_side,
   input  logic                   req_flag,
   input  logic [WORD_BITS-1:0]   req_write_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_BITS-1:0]   rsp_read_word,
   output logic                   rsp_read_valid,
   output logic                   rsp_dropped_oldest,
   output logic                   rsp_push_failed,
   output logic [2:0]             rsp_event_code,
   output logic                   rsp_event_side,
   output logic [7:0]             rsp_event_port_id,
   output logic [FILL_BITS-1:0]   rsp_fill_level
);
   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = FILL_BITS;
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);
   localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS:0]   DEPTH_SUM = (CNT_BITS + 1)'(DEPTH);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // latched item
   bqec_pkg::op_type     op_ff;
   logic                 side_ff;
   logic                 flag_ff;
   logic [WORD_BITS-1:0] word_ff;

   // queue and notification state
   logic [IDX_BITS-1:0] head_ff,  head_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [1:0]          carm_ff,  carm_in;
   logic [1:0]          parm_ff,  parm_in;
   logic [1:0]          conn_ff,  conn_in;

   // result register
   logic                 out_valid_ff;
   logic [WORD_BITS-1:0] rword_ff,   rword_in;
   logic                 rvalid_ff,  rvalid_in;
   logic                 dropped_ff, dropped_in;
   logic                 failed_ff,  failed_in;
   logic [2:0]           ev_ff,      ev_in;
   logic                 evside_ff,  evside_in;
   logic [7:0]           evid_ff,    evid_in;

   logic                    full, empty, blocking, drop;
   logic                    we;
   logic [IDX_BITS-1:0]     waddr;
   logic [IDX_BITS-1:0]     head_next;
   logic [IDX_BITS-1:0]     head_after;
   logic [CNT_BITS-1:0]     count_after;
   logic [CNT_BITS:0]       wsum;
   logic                    other;
   logic                    other_conn;
   bqec_pkg::arm_result_type cfire, pfire;

   assign full       = (count_ff == DEPTH_CNT);
   assign empty      = (count_ff == '0);
   assign blocking   = (conn_ff == 2'b11) ? cfg.block_conn : cfg.block_uncon;
   assign drop       = full && !blocking;
   assign head_next  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_after = drop ? head_next : head_ff;
   assign count_after = drop ? count_ff - 1'b1 : count_ff;
   assign wsum       = {1'b0, count_after} + (CNT_BITS + 1)'(head_after);
   assign waddr      = (wsum >= DEPTH_SUM) ? IDX_BITS'(wsum - DEPTH_SUM)
                                           : IDX_BITS'(wsum);
   assign other      = ~side_ff;
   assign other_conn = other ? conn_ff[1] : conn_ff[0];
   assign cfire      = bqec_pkg::arm_fire(cfg.cons_mode, carm_ff);
   assign pfire      = bqec_pkg::arm_fire(cfg.prod_mode, parm_ff);

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      carm_in    = carm_ff;
      parm_in    = parm_ff;
      conn_in    = conn_ff;
      we         = 1'b0;
      rword_in   = '0;
      rvalid_in  = 1'b0;
      dropped_in = 1'b0;
      failed_in  = 1'b0;
      ev_in      = bqec_pkg::EV_NONE;
      evside_in  = 1'b0;
      evid_in    = 8'd0;
      id_clear.cons = 1'b0;
      id_clear.prod = 1'b0;
      case (op_ff)
         bqec_pkg::OP_SEND: begin
            dropped_in = drop;
            head_in    = head_after;
            if (!full || drop) begin
               we       = 1'b1;
               count_in = count_after + 1'b1;
            end else begin
               failed_in = 1'b1;
            end
            if (parm_ff == bqec_pkg::ARM_HELD_OP) begin
               parm_in = bqec_pkg::ARM_READY;
            end
            if (conn_ff[0]) begin
               carm_in = cfire.arm;
               if (cfire.fire) begin
                  ev_in     = bqec_pkg::EV_DATA_READY;
                  evside_in = bqec_pkg::SIDE_CONS;
                  evid_in   = cfg.cons_id;
               end
            end
         end
         bqec_pkg::OP_RECV, bqec_pkg::OP_SIG_FULL: begin
            if (op_ff == bqec_pkg::OP_SIG_FULL && full) begin
               if (conn_ff[0]) begin
                  ev_in     = bqec_pkg::EV_DATA_READY;
                  evside_in = bqec_pkg::SIDE_CONS;
                  evid_in   = cfg.cons_id;
               end
            end else begin
               if (op_ff == bqec_pkg::OP_RECV && !empty) begin
                  rword_in  = rd_data_ff;
                  rvalid_in = 1'b1;
                  head_in   = head_next;
                  count_in  = count_ff - 1'b1;
               end
               if (carm_ff == bqec_pkg::ARM_HELD_OP) begin
                  carm_in = bqec_pkg::ARM_READY;
               end
               if (conn_ff[1]) begin
                  parm_in = pfire.arm;
                  if (pfire.fire) begin
                     ev_in     = bqec_pkg::EV_SPACE_READY;
                     evside_in = bqec_pkg::SIDE_PROD;
                     evid_in   = cfg.prod_id;
                  end
               end
            end
         end
         bqec_pkg::OP_CONFIRM: begin
            if (side_ff == bqec_pkg::SIDE_PROD) begin
               parm_in = full ? bqec_pkg::ARM_READY : bqec_pkg::ARM_HELD_OP;
            end else begin
               carm_in = empty ? bqec_pkg::ARM_READY : bqec_pkg::ARM_HELD_OP;
            end
         end
         bqec_pkg::OP_DISCON: begin
            if (other_conn) begin
               ev_in     = flag_ff ? bqec_pkg::EV_PORT_ERROR : bqec_pkg::EV_DISCONNECT;
               evside_in = other;
               evid_in   = other ? cfg.prod_id : cfg.cons_id;
            end
            if (side_ff == bqec_pkg::SIDE_PROD) begin
               id_clear.prod = 1'b1;
               conn_in[1]    = 1'b0;
            end else begin
               id_clear.cons = 1'b1;
               conn_in[0]    = 1'b0;
            end
            // nobody left on either side: empty the queue
            if (conn_in == 2'b00) begin
               head_in  = '0;
               count_in = '0;
            end
         end
         bqec_pkg::OP_ACTIVATE: begin
            if (other_conn) begin
               ev_in     = flag_ff ? bqec_pkg::EV_START : bqec_pkg::EV_STOP;
               evside_in = other;
               evid_in   = other ? cfg.prod_id : cfg.cons_id;
            end
         end
         bqec_pkg::OP_CONNECT: begin
            if (side_ff == bqec_pkg::SIDE_PROD) begin
               conn_in[1] = 1'b1;
            end else begin
               conn_in[0] = 1'b1;
            end
         end
         default: head_in = head_ff;
      endcase
      if (!cmd.commit) begin
         id_clear.cons = 1'b0;
         id_clear.prod = 1'b0;
      end
   end

   // memory: read at head when an item is taken, write on commit
   always_ff @(posedge clock) begin
      if (cmd.commit && we) begin
         mem[waddr] <= word_ff;
      end
      if (cmd.latch) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= bqec_pkg::op_type'(req_opcode);
         side_ff <= req_side;
         flag_ff <= req_flag;
         word_ff <= req_write_word;
      end
      if (cmd.commit) begin
         rword_ff   <= rword_in;
         rvalid_ff  <= rvalid_in;
         dropped_ff <= dropped_in;
         failed_ff  <= failed_in;
         ev_ff      <= ev_in;
         evside_ff  <= evside_in;
         evid_ff    <= evid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         carm_ff      <= bqec_pkg::ARM_READY;
         parm_ff      <= bqec_pkg::ARM_READY;
         conn_ff      <= 2'b00;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            head_ff  <= head_in;
            count_ff <= count_in;
            carm_ff  <= carm_in;
            parm_ff  <= parm_in;
            conn_ff  <= conn_in;
         end
         if (cmd.commit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_busy    = out_valid_ff && !rsp_ready;
   assign rsp_valid          = out_valid_ff;
   assign rsp_read_word      = rword_ff;
   assign rsp_read_valid     = rvalid_ff;
   assign rsp_dropped_oldest = dropped_ff;
   assign rsp_push_failed    = failed_ff;
   assign rsp_event_code     = ev_ff;
   assign rsp_event_side     = evside_ff;
   assign rsp_event_port_id  = evid_ff;
   assign rsp_fill_level     = count_ff;
endmodule

/* rtl/buffer_queue_with_event_coalescing.sv */
// Top level of the buffer-handle queue with coalesced notifications.
// Depends on bqec_pkg, bqec_req_if, bqec_rsp_if, bqec_csr, bqec_ctrl, bqec_dp.
//
//   channel   direction   handshake              payload
//   req       in          valid/ready            opcode, side, flag, write_word
//   rsp       out         valid/ready            read_word .. fill_level
//   APB       in/out      psel/penable, pready   paddr, pwdata, prdata
//
// Each operation is accepted in ST_IDLE, which reads the queue head from the
// memory, then committed in ST_EXEC, which updates the queue state and loads
// the result register. A result waits in its register; the next operation is
// accepted meanwhile and held in ST_EXEC until that result beat is taken.
// Reset is synchronous and needs no clearing pass; the queue memory is not reset.
module buffer_queue_with_event_coalescing #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   bqec_req_if.sink                       req,
   bqec_rsp_if.source                     rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bqec_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   localparam int FILL_BITS = $clog2(DEPTH + 1);

   bqec_pkg::cfg_type       cfg;
   bqec_pkg::id_clear_type  id_clear;
   bqec_pkg::ctrl_cmd_type  cmd;
   bqec_pkg::dp_status_type status;
   logic [FILL_BITS-1:0]    fill_level;

   bqec_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .id_clear (id_clear),
      .cfg      (cfg)
   );

   bqec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bqec_dp #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS),
      .FILL_BITS (FILL_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg),
      .id_clear           (id_clear),
      .req_opcode         (req.opcode),
      .req_side           (req.side),
      .req_flag           (req.flag),
      .req_write_word     (req.write_word),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .rsp_read_word      (rsp.read_word),
      .rsp_read_valid     (rsp.read_valid),
      .rsp_dropped_oldest (rsp.dropped_oldest),
      .rsp_push_failed    (rsp.push_failed),
      .rsp_event_code     (rsp.event_code),
      .rsp_event_side     (rsp.event_side),
      .rsp_event_port_id  (rsp.event_port_id),
      .rsp_fill_level     (fill_level)
   );

   assign rsp.fill_level = fill_level;
endmodule
